// File: rtl/ard_pkg.sv
// Shared types, code tables and decode functions for the alert record decoder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package ard_pkg;

    // Band codes as they appear on the result beat.
    typedef enum logic [2:0] {
        BAND_NONE  = 3'd0,
        BAND_LASER = 3'd1,
        BAND_K     = 3'd2,
        BAND_KA    = 3'd3,
        BAND_X     = 3'd4
    } t_band;

    // Arrow direction codes.
    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_FRONT = 2'd1,
        DIR_SIDE  = 2'd2,
        DIR_REAR  = 2'd3
    } t_dir;

    // Known band/arrow byte codes.
    localparam logic [7:0] CODE_NONE      = 8'h00;
    localparam logic [7:0] CODE_LASER_F   = 8'h21;
    localparam logic [7:0] CODE_LASER_R   = 8'h81;
    localparam logic [7:0] CODE_K_F       = 8'h24;
    localparam logic [7:0] CODE_K_S       = 8'h44;
    localparam logic [7:0] CODE_K_R       = 8'h84;
    localparam logic [7:0] CODE_KA_F      = 8'h22;
    localparam logic [7:0] CODE_KA_S      = 8'h42;
    localparam logic [7:0] CODE_KA_R      = 8'h82;
    localparam logic [7:0] CODE_X_F       = 8'h28;
    localparam logic [7:0] CODE_X_S       = 8'h48;
    localparam logic [7:0] CODE_X_R       = 8'h88;

    // Aux byte codes.
    localparam logic [7:0] AUX_PRIORITY   = 8'h80;
    localparam logic [7:0] AUX_JUNK       = 8'h40;

    // Bar ladders: inclusive upper bounds for one to seven bars, entry 0 last in each list.
    localparam int unsigned LADDER_STEPS  = 7;
    localparam logic [3:0]  BARS_FULL     = 4'd8;
    localparam logic [LADDER_STEPS-1:0][7:0] LADDER_X =
        {8'hCF, 8'hC4, 8'hBC, 8'hB3, 8'hA9, 8'h9F, 8'h95};
    localparam logic [LADDER_STEPS-1:0][7:0] LADDER_K =
        {8'hC1, 8'hB7, 8'hAD, 8'hA3, 8'h99, 8'h8F, 8'h87};
    localparam logic [LADDER_STEPS-1:0][7:0] LADDER_KA =
        {8'hB9, 8'hB2, 8'hAB, 8'hA4, 8'h9D, 8'h96, 8'h8F};

    // One input beat: the seven record bytes.
    typedef struct packed {
        logic [7:0] count_index_byte;
        logic [7:0] freq_high;
        logic [7:0] freq_low;
        logic [7:0] front_level;
        logic [7:0] rear_level;
        logic [7:0] band_arrow;
        logic [7:0] aux_byte;
    } t_rec;

    // One result beat.
    typedef struct packed {
        logic [3:0]  alert_count;
        logic [3:0]  alert_index;
        logic        count_ok;
        logic [15:0] freq_mhz;
        t_band       band;
        t_dir        direction;
        logic        band_ok;
        logic [3:0]  front_bars;
        logic [3:0]  rear_bars;
        logic [3:0]  peak_bars;
        logic        is_priority;
        logic        is_junk;
    } t_res;

    // Contents of the decode stage register.
    typedef struct packed {
        logic [3:0]  alert_count;
        logic [3:0]  alert_index;
        logic        count_ok;
        logic [15:0] freq_mhz;
        t_band       band;
        t_dir        direction;
        logic        band_ok;
        logic [7:0]  front_level;
        logic [7:0]  rear_level;
        logic        is_priority;
        logic        is_junk;
    } t_dec;

    // Contents of the bar stage register.
    typedef struct packed {
        logic [3:0]  alert_count;
        logic [3:0]  alert_index;
        logic        count_ok;
        logic [15:0] freq_mhz;
        t_band       band;
        t_dir        direction;
        logic        band_ok;
        logic [3:0]  front_bars;
        logic [3:0]  rear_bars;
        logic        is_priority;
        logic        is_junk;
    } t_bar;

    // Result of the band/arrow lookup.
    typedef struct packed {
        t_band band;
        t_dir  direction;
        logic  ok;
    } t_band_dir;

    // Looks up a band/arrow byte; unknown codes give no band and a clear ok.
    function automatic t_band_dir decode_band(input logic [7:0] code);
        t_band_dir bd;
        bd.band      = BAND_NONE;
        bd.direction = DIR_NONE;
        bd.ok        = 1'b1;
        unique case (code)
            CODE_NONE:    begin bd.band = BAND_NONE;  bd.direction = DIR_NONE;  end
            CODE_LASER_F: begin bd.band = BAND_LASER; bd.direction = DIR_FRONT; end
            CODE_LASER_R: begin bd.band = BAND_LASER; bd.direction = DIR_REAR;  end
            CODE_K_F:     begin bd.band = BAND_K;     bd.direction = DIR_FRONT; end
            CODE_K_S:     begin bd.band = BAND_K;     bd.direction = DIR_SIDE;  end
            CODE_K_R:     begin bd.band = BAND_K;     bd.direction = DIR_REAR;  end
            CODE_KA_F:    begin bd.band = BAND_KA;    bd.direction = DIR_FRONT; end
            CODE_KA_S:    begin bd.band = BAND_KA;    bd.direction = DIR_SIDE;  end
            CODE_KA_R:    begin bd.band = BAND_KA;    bd.direction = DIR_REAR;  end
            CODE_X_F:     begin bd.band = BAND_X;     bd.direction = DIR_FRONT; end
            CODE_X_S:     begin bd.band = BAND_X;     bd.direction = DIR_SIDE;  end
            CODE_X_R:     begin bd.band = BAND_X;     bd.direction = DIR_REAR;  end
            default:      bd.ok = 1'b0;
        endcase
        return bd;
    endfunction

    // Maps a raw level to bars on the ladder of the given band.
    function automatic logic [3:0] level_to_bars(input logic [7:0] level,
                                                 input t_band band);
        logic [LADDER_STEPS-1:0][7:0] ladder;
        logic                         has_ladder;
        logic [3:0]                   bars;
        has_ladder = 1'b1;
        ladder     = LADDER_X;
        case (band)
            BAND_X:  ladder = LADDER_X;
            BAND_K:  ladder = LADDER_K;
            BAND_KA: ladder = LADDER_KA;
            default: has_ladder = 1'b0;
        endcase
        // The ladders rise, so the lowest step that holds the level wins.
        bars = BARS_FULL;
        for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
            if (level <= ladder[i]) begin
                bars = 4'(i + 1);
            end
        end
        if (!has_ladder || level == 8'd0) begin
            bars = 4'd0;
        end
        return bars;
    endfunction

endpackage

`default_nettype wire

// File: rtl/alert_record_decoder_unit.sv
// Alert record decoder: takes one seven-byte radar alert record per beat and
// returns one decoded result beat for it, in order. It accepts a record every
// clock while o_stall is low and passes each record through three register
// stages: decode (count/index check, frequency, band/arrow lookup, aux flags),
// bar ladders for the front and rear levels, and the peak select that feeds
// the output register. A stall on the output holds the result; the stages
// ahead keep filling, so up to three records are in flight. The block keeps
// no state between records. Depends on ard_pkg, ard_decode, ard_bars and
// ard_peak.
`default_nettype none

module alert_record_decoder_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ard_pkg::t_rec i_rec,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ard_pkg::t_res      o_res
);

    logic          dec_valid;
    logic          dec_stall;
    ard_pkg::t_dec dec_data;
    logic          bar_valid;
    logic          bar_stall;
    ard_pkg::t_bar bar_data;

    // Stage one: field decode.
    ard_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_rec   (i_rec),
        .o_valid (dec_valid),
        .i_stall (dec_stall),
        .o_dec   (dec_data)
    );

    // Stage two: bar ladders.
    ard_bars u_bars (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_stall (dec_stall),
        .i_dec   (dec_data),
        .o_valid (bar_valid),
        .i_stall (bar_stall),
        .o_bar   (bar_data)
    );

    // Stage three: peak select and output register.
    ard_peak u_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bar_valid),
        .o_stall (bar_stall),
        .i_bar   (bar_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/ard_decode.sv
// First pipeline stage: splits the record bytes, checks count and index,
// rebuilds the frequency, looks up band and arrow and tests the aux byte.
// Depends on ard_pkg.
`default_nettype none

module ard_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ard_pkg::t_rec i_rec,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ard_pkg::t_dec      o_dec
);

    logic               r_valid;
    ard_pkg::t_dec      r_dec;
    ard_pkg::t_dec      n_dec;
    ard_pkg::t_band_dir bd;
    logic               ready;

    // The stage takes a beat when it is empty or its content moves on.
    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    // Decode logic for the incoming record.
    always_comb begin
        bd                = ard_pkg::decode_band(i_rec.band_arrow);
        n_dec.alert_count = i_rec.count_index_byte[3:0];
        n_dec.alert_index = i_rec.count_index_byte[7:4];
        n_dec.count_ok    = (n_dec.alert_count == 4'd0 && n_dec.alert_index == 4'd0) ||
                            (n_dec.alert_index != 4'd0 &&
                             n_dec.alert_index <= n_dec.alert_count);
        n_dec.freq_mhz    = {i_rec.freq_high, i_rec.freq_low};
        n_dec.band        = bd.band;
        n_dec.direction   = bd.direction;
        n_dec.band_ok     = bd.ok;
        n_dec.front_level = i_rec.front_level;
        n_dec.rear_level  = i_rec.rear_level;
        n_dec.is_priority = (i_rec.aux_byte == ard_pkg::AUX_PRIORITY);
        n_dec.is_junk     = (i_rec.aux_byte == ard_pkg::AUX_JUNK);
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ard_bars.sv
// Second pipeline stage: maps the front and rear levels to bars through
// the ladder of the decoded band. Depends on ard_pkg.
`default_nettype none

module ard_bars (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ard_pkg::t_dec i_dec,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ard_pkg::t_bar      o_bar
);

    logic          r_valid;
    ard_pkg::t_bar r_bar;
    ard_pkg::t_bar n_bar;
    logic          ready;

    // The stage takes a beat when it is empty or its content moves on.
    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_bar   = r_bar;

    // Ladder compares for both antennas; the rest passes along.
    always_comb begin
        n_bar.alert_count = i_dec.alert_count;
        n_bar.alert_index = i_dec.alert_index;
        n_bar.count_ok    = i_dec.count_ok;
        n_bar.freq_mhz    = i_dec.freq_mhz;
        n_bar.band        = i_dec.band;
        n_bar.direction   = i_dec.direction;
        n_bar.band_ok     = i_dec.band_ok;
        n_bar.front_bars  = ard_pkg::level_to_bars(i_dec.front_level, i_dec.band);
        n_bar.rear_bars   = ard_pkg::level_to_bars(i_dec.rear_level, i_dec.band);
        n_bar.is_priority = i_dec.is_priority;
        n_bar.is_junk     = i_dec.is_junk;
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_bar <= n_bar;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ard_peak.sv
// Third pipeline stage and output register: picks the peak bar count and
// forms the result beat. Depends on ard_pkg.
`default_nettype none

module ard_peak (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ard_pkg::t_bar i_bar,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ard_pkg::t_res      o_res
);

    logic          r_valid;
    ard_pkg::t_res r_res;
    ard_pkg::t_res n_res;
    logic          ready;

    // The output register takes a beat when it is empty or its beat is taken.
    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Peak of the two bar counts and assembly of the result.
    always_comb begin
        n_res.alert_count = i_bar.alert_count;
        n_res.alert_index = i_bar.alert_index;
        n_res.count_ok    = i_bar.count_ok;
        n_res.freq_mhz    = i_bar.freq_mhz;
        n_res.band        = i_bar.band;
        n_res.direction   = i_bar.direction;
        n_res.band_ok     = i_bar.band_ok;
        n_res.front_bars  = i_bar.front_bars;
        n_res.rear_bars   = i_bar.rear_bars;
        n_res.peak_bars   = (i_bar.rear_bars > i_bar.front_bars) ? i_bar.rear_bars
                                                                 : i_bar.front_bars;
        n_res.is_priority = i_bar.is_priority;
        n_res.is_junk     = i_bar.is_junk;
    end

    // Output valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ard_checker.sv
// Port-level checks on the alert record decoder result beats, bound to the
// top level. Depends on ard_pkg and alert_record_decoder_unit.
`default_nettype none

module ard_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire ard_pkg::t_res o_res
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result beat changed while stalled");

    // The peak is the larger of the two bar counts.
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.peak_bars >= o_res.front_bars) &&
                    (o_res.peak_bars >= o_res.rear_bars) &&
                    ((o_res.peak_bars == o_res.front_bars) ||
                     (o_res.peak_bars == o_res.rear_bars)))
        else $error("peak bars do not match front and rear bars");

    // An unknown code gives no band, no direction and no bars.
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.band_ok |-> (o_res.band == ard_pkg::BAND_NONE) &&
                                      (o_res.direction == ard_pkg::DIR_NONE) &&
                                      (o_res.peak_bars == 4'd0))
        else $error("unknown band code with band, direction or bars set");

    // Laser and no-band results carry no bars.
    a_laser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_res.band == ard_pkg::BAND_LASER) ||
                    (o_res.band == ard_pkg::BAND_NONE)) |-> (o_res.peak_bars == 4'd0))
        else $error("bars reported for a band without a ladder");

    // The count check agrees with the nibbles it reports.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.count_ok ==
            ((o_res.alert_count == 4'd0 && o_res.alert_index == 4'd0) ||
             (o_res.alert_index != 4'd0 && o_res.alert_index <= o_res.alert_count)))
        else $error("count check disagrees with count and index");

endmodule

bind alert_record_decoder_unit ard_checker u_ard_checker (.*);

`default_nettype wire

// File: sim/alert_record_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for alert_record_decoder_unit: records go in through a queued driver,
// results are predicted per accepted beat and compared field by field. Depends on ard_pkg.

module alert_record_decoder_unit_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_RECORDS  = 360;
    localparam int TAIL_CYCLES    = 8;
    localparam int LADDER_RUNGS   = 7;
    localparam int KNOWN_CODES    = 12;

    // Inclusive upper level for one bar up to seven bars, lowest rung in the low byte.
    localparam logic [55:0] BOUNDS_X  = {8'hCF, 8'hC4, 8'hBC, 8'hB3, 8'hA9, 8'h9F, 8'h95};
    localparam logic [55:0] BOUNDS_K  = {8'hC1, 8'hB7, 8'hAD, 8'hA3, 8'h99, 8'h8F, 8'h87};
    localparam logic [55:0] BOUNDS_KA = {8'hB9, 8'hB2, 8'hAB, 8'hA4, 8'h9D, 8'h96, 8'h8F};

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    ard_pkg::t_rec i_rec   = '0;
    logic          o_stall;
    logic          o_valid;
    ard_pkg::t_res o_res;

    ard_pkg::t_rec queued_records[$];
    ard_pkg::t_res predicted_results[$];

    int   idle_pct       = 0;
    int   stall_pct      = 0;
    int   holdoff_asked  = 0;
    int   holdoff_served = 0;
    int   holdoff_left   = 0;
    int   idle_cycles    = 0;
    int   mismatches     = 0;
    bit   rec_taken      = 1'b0;
    bit   res_taken      = 1'b0;

    alert_record_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_rec   (i_rec),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always #6 i_clk = ~i_clk;

    // Maps a level to bars on the ladder of a band; bands without a ladder give none.
    function automatic logic [3:0] bars_for_level(input logic [7:0] level,
                                                  input ard_pkg::t_band band);
        logic [55:0] bounds;
        case (band)
            ard_pkg::BAND_X:  bounds = BOUNDS_X;
            ard_pkg::BAND_K:  bounds = BOUNDS_K;
            ard_pkg::BAND_KA: bounds = BOUNDS_KA;
            default: return 4'd0;
        endcase
        if (level == 8'd0) begin
            return 4'd0;
        end
        for (int i = 0; i < LADDER_RUNGS; i++) begin
            if (level <= bounds[i*8 +: 8]) begin
                return 4'(i + 1);
            end
        end
        return 4'(LADDER_RUNGS + 1);
    endfunction

    // Works out the result beat that one record must produce.
    function automatic ard_pkg::t_res decode_record(input ard_pkg::t_rec rec);
        ard_pkg::t_res res;
        logic [3:0]    cnt;
        logic [3:0]    idx;
        cnt = rec.count_index_byte[3:0];
        idx = rec.count_index_byte[7:4];
        res = '0;
        res.alert_count = cnt;
        res.alert_index = idx;
        res.count_ok    = (cnt == 4'd0 && idx == 4'd0) || (idx >= 4'd1 && idx <= cnt);
        res.freq_mhz    = {rec.freq_high, rec.freq_low};
        res.band        = ard_pkg::BAND_NONE;
        res.direction   = ard_pkg::DIR_NONE;
        res.band_ok     = 1'b1;
        case (rec.band_arrow)
            ard_pkg::CODE_NONE: begin
                res.band = ard_pkg::BAND_NONE;  res.direction = ard_pkg::DIR_NONE;
            end
            ard_pkg::CODE_LASER_F: begin
                res.band = ard_pkg::BAND_LASER; res.direction = ard_pkg::DIR_FRONT;
            end
            ard_pkg::CODE_LASER_R: begin
                res.band = ard_pkg::BAND_LASER; res.direction = ard_pkg::DIR_REAR;
            end
            ard_pkg::CODE_K_F: begin
                res.band = ard_pkg::BAND_K;     res.direction = ard_pkg::DIR_FRONT;
            end
            ard_pkg::CODE_K_S: begin
                res.band = ard_pkg::BAND_K;     res.direction = ard_pkg::DIR_SIDE;
            end
            ard_pkg::CODE_K_R: begin
                res.band = ard_pkg::BAND_K;     res.direction = ard_pkg::DIR_REAR;
            end
            ard_pkg::CODE_KA_F: begin
                res.band = ard_pkg::BAND_KA;    res.direction = ard_pkg::DIR_FRONT;
            end
            ard_pkg::CODE_KA_S: begin
                res.band = ard_pkg::BAND_KA;    res.direction = ard_pkg::DIR_SIDE;
            end
            ard_pkg::CODE_KA_R: begin
                res.band = ard_pkg::BAND_KA;    res.direction = ard_pkg::DIR_REAR;
            end
            ard_pkg::CODE_X_F: begin
                res.band = ard_pkg::BAND_X;     res.direction = ard_pkg::DIR_FRONT;
            end
            ard_pkg::CODE_X_S: begin
                res.band = ard_pkg::BAND_X;     res.direction = ard_pkg::DIR_SIDE;
            end
            ard_pkg::CODE_X_R: begin
                res.band = ard_pkg::BAND_X;     res.direction = ard_pkg::DIR_REAR;
            end
            default: res.band_ok = 1'b0;
        endcase
        res.front_bars  = bars_for_level(rec.front_level, res.band);
        res.rear_bars   = bars_for_level(rec.rear_level, res.band);
        res.peak_bars   = (res.rear_bars > res.front_bars) ? res.rear_bars : res.front_bars;
        res.is_priority = (rec.aux_byte == ard_pkg::AUX_PRIORITY);
        res.is_junk     = (rec.aux_byte == ard_pkg::AUX_JUNK);
        return res;
    endfunction

    function automatic ard_pkg::t_rec make_rec(input logic [7:0] cib, input logic [7:0] fhi,
                                               input logic [7:0] flo, input logic [7:0] front,
                                               input logic [7:0] rear, input logic [7:0] code,
                                               input logic [7:0] aux);
        ard_pkg::t_rec rec;
        rec.count_index_byte = cib;
        rec.freq_high        = fhi;
        rec.freq_low         = flo;
        rec.front_level      = front;
        rec.rear_level       = rear;
        rec.band_arrow       = code;
        rec.aux_byte         = aux;
        return rec;
    endfunction

    function automatic logic [7:0] known_code(input int unsigned k);
        case (k)
            0:       return ard_pkg::CODE_NONE;
            1:       return ard_pkg::CODE_LASER_F;
            2:       return ard_pkg::CODE_LASER_R;
            3:       return ard_pkg::CODE_K_F;
            4:       return ard_pkg::CODE_K_S;
            5:       return ard_pkg::CODE_K_R;
            6:       return ard_pkg::CODE_KA_F;
            7:       return ard_pkg::CODE_KA_S;
            8:       return ard_pkg::CODE_KA_R;
            9:       return ard_pkg::CODE_X_F;
            10:      return ard_pkg::CODE_X_S;
            default: return ard_pkg::CODE_X_R;
        endcase
    endfunction

    // Levels cluster around the ladder rungs, with the ends of the range mixed in.
    function automatic logic [7:0] random_level();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4) begin
            return 8'($urandom_range(8'hD8, 8'h80));
        end else if (sel == 4) begin
            return 8'h00;
        end else if (sel == 5) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed records with random content, plus plain noise.
    function automatic ard_pkg::t_rec random_rec();
        ard_pkg::t_rec rec;
        int unsigned   sel;
        int unsigned   cnt;
        int unsigned   idx;
        sel = $urandom_range(9);
        if (sel < 5) begin
            cnt = $urandom_range(15, 1);
            idx = $urandom_range(cnt, 1);
            rec.count_index_byte = {4'(idx), 4'(cnt)};
        end else if (sel == 5) begin
            rec.count_index_byte = 8'h00;
        end else begin
            rec.count_index_byte = 8'($urandom_range(255));
        end
        rec.freq_high   = 8'($urandom_range(255));
        rec.freq_low    = 8'($urandom_range(255));
        rec.front_level = random_level();
        rec.rear_level  = random_level();
        if ($urandom_range(9) < 7) begin
            rec.band_arrow = known_code($urandom_range(KNOWN_CODES - 1));
        end else begin
            rec.band_arrow = 8'($urandom_range(255));
        end
        sel = $urandom_range(3);
        if (sel == 0) begin
            rec.aux_byte = ard_pkg::AUX_PRIORITY;
        end else if (sel == 1) begin
            rec.aux_byte = ard_pkg::AUX_JUNK;
        end else begin
            rec.aux_byte = 8'($urandom_range(255));
        end
        return rec;
    endfunction

    // Appends one record to the driver's pending list.
    task automatic add_record(input ard_pkg::t_rec rec);
        queued_records = {queued_records, rec};
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input ard_pkg::t_res want, input ard_pkg::t_res got);
        check_field("alert_count", 16'(want.alert_count), 16'(got.alert_count));
        check_field("alert_index", 16'(want.alert_index), 16'(got.alert_index));
        check_field("count_ok", 16'(want.count_ok), 16'(got.count_ok));
        check_field("freq_mhz", want.freq_mhz, got.freq_mhz);
        check_field("band", 16'(want.band), 16'(got.band));
        check_field("direction", 16'(want.direction), 16'(got.direction));
        check_field("band_ok", 16'(want.band_ok), 16'(got.band_ok));
        check_field("front_bars", 16'(want.front_bars), 16'(got.front_bars));
        check_field("rear_bars", 16'(want.rear_bars), 16'(got.rear_bars));
        check_field("peak_bars", 16'(want.peak_bars), 16'(got.peak_bars));
        check_field("is_priority", 16'(want.is_priority), 16'(got.is_priority));
        check_field("is_junk", 16'(want.is_junk), 16'(got.is_junk));
    endtask

    // Polled at the rising edge, where the monitor alone touches the result queue.
    task automatic wait_drained();
        while (queued_records.size() != 0 || i_valid || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int idle, input int stall, input bit holdoff);
        @(posedge i_clk);
        idle_pct  = idle;
        stall_pct = stall;
        if (holdoff) begin
            holdoff_asked++;
        end
        repeat (PHASE_RECORDS) add_record(random_rec());
        wait_drained();
    endtask

    // Driver: a stalled beat is held; otherwise the next record is offered or the bus idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || rec_taken) begin
            if (queued_records.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_valid <= 1'b1;
                i_rec   <= queued_records.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: a requested hold-off stalls for a fixed stretch, else stalls at random.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            i_stall      <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_served != holdoff_asked) begin
            i_stall        <= 1'b1;
            holdoff_served <= holdoff_asked;
            holdoff_left   <= HOLDOFF_CYCLES - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predicts on each accepted record beat and checks each accepted result beat.
    always @(posedge i_clk) begin
        rec_taken = i_rst_n && i_valid && !o_stall;
        res_taken = i_rst_n && o_valid && !i_stall;
        if (rec_taken) begin
            predicted_results = {predicted_results, decode_record(i_rec)};
        end
        if (res_taken) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result beat with no record pending: expected none, got %h",
                         $time, o_res);
                mismatches++;
            end else begin
                check_result(predicted_results.pop_front(), o_res);
            end
        end
        if (rec_taken || res_taken) begin
            idle_cycles = 0;
        end else if (queued_records.size() != 0 || i_valid || predicted_results.size() != 0) begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed records: field extremes, every band/arrow code, ladder rung edges,
        // invalid count/index pairs, unknown codes and the aux flag values.
        add_record(make_rec(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ard_pkg::CODE_NONE, 8'h00));
        add_record(make_rec(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_record(make_rec(8'h11, 8'h00, 8'h01, 8'h87, 8'h88, ard_pkg::CODE_K_F,
                            ard_pkg::AUX_PRIORITY));
        add_record(make_rec(8'h21, 8'h01, 8'h00, 8'hC1, 8'hC2, ard_pkg::CODE_K_S,
                            ard_pkg::AUX_JUNK));
        add_record(make_rec(8'h05, 8'h80, 8'h00, 8'h01, 8'h00, ard_pkg::CODE_K_R, 8'hC0));
        add_record(make_rec(8'h10, 8'h27, 8'h10, 8'h8F, 8'h90, ard_pkg::CODE_KA_F, 8'h00));
        add_record(make_rec(8'h33, 8'h5A, 8'h5A, 8'hB9, 8'hBA, ard_pkg::CODE_KA_S,
                            ard_pkg::AUX_PRIORITY));
        add_record(make_rec(8'h8F, 8'h00, 8'hFF, 8'h00, 8'hFF, ard_pkg::CODE_KA_R,
                            ard_pkg::AUX_JUNK));
        add_record(make_rec(8'h12, 8'h2C, 8'h4A, 8'h95, 8'h96, ard_pkg::CODE_X_F, 8'h01));
        add_record(make_rec(8'h22, 8'h2C, 8'h4B, 8'hCF, 8'hD0, ard_pkg::CODE_X_S, 8'h7F));
        add_record(make_rec(8'h44, 8'h5D, 8'hC0, 8'h00, 8'hFF, ard_pkg::CODE_X_R, 8'h81));
        add_record(make_rec(8'h11, 8'h00, 8'h00, 8'hFF, 8'hFF, ard_pkg::CODE_LASER_F,
                            ard_pkg::AUX_PRIORITY));
        add_record(make_rec(8'h11, 8'hFF, 8'h00, 8'hFF, 8'hFF, ard_pkg::CODE_LASER_R,
                            8'h00));
        add_record(make_rec(8'h00, 8'h12, 8'h34, 8'hFF, 8'hFF, ard_pkg::CODE_NONE,
                            ard_pkg::AUX_PRIORITY));
        // Unknown band/arrow bytes next to known ones.
        add_record(make_rec(8'h11, 8'h60, 8'h00, 8'hC0, 8'hC0, 8'h23, 8'h00));
        add_record(make_rec(8'h11, 8'hA0, 8'h50, 8'hA0, 8'h50, 8'h80, 8'h01));
        add_record(make_rec(8'h11, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00));
        // Index above a zero count and a zero index under a full count.
        add_record(make_rec(8'hF0, 8'h55, 8'hAA, 8'hA9, 8'hAA, ard_pkg::CODE_X_F, 8'h20));
        add_record(make_rec(8'h0F, 8'hAA, 8'h55, 8'h99, 8'h9A, ard_pkg::CODE_K_F, 8'h02));
        add_record(make_rec(8'hFF, 8'h7F, 8'h80, 8'h9D, 8'h9E, ard_pkg::CODE_KA_F,
                            8'h00));
        add_record(make_rec(8'h9A, 8'h0A, 8'h0B, 8'hB3, 8'hBD, ard_pkg::CODE_X_R, 8'h00));
        add_record(make_rec(8'h77, 8'h0A, 8'h0C, 8'hC4, 8'hC5, ard_pkg::CODE_X_S, 8'h00));
        wait_drained();

        // Random records under each idling pattern, then a long receiver hold-off.
        run_random(0, 0, 1'b0);
        run_random(68, 0, 1'b0);
        run_random(0, 68, 1'b0);
        run_random(38, 38, 1'b0);
        run_random(0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
